FILE: rtl/tdcs_pkg.sv
package tdcs_pkg;

	localparam int MaxProcs = 8;
	localparam int SlotW = 3;
	localparam int CntW = 4;

	localparam logic [2:0] PolFcfs = 3'd0;
	localparam logic [2:0] PolSjf = 3'd1;
	localparam logic [2:0] PolPrio = 3'd2;
	localparam logic [2:0] PolRr = 3'd3;
	localparam logic [2:0] PolPsjf = 3'd4;
	localparam logic [2:0] PolPprio = 3'd5;

	localparam logic [1:0] CfgPolicy = 2'd0;
	localparam logic [1:0] CfgSlice = 2'd1;
	localparam logic [1:0] CfgCount = 2'd2;

	localparam logic [3:0] FReady = 4'd1;
	localparam logic [3:0] FWait = 4'd2;
	localparam logic [3:0] FRun = 4'd4;
	localparam logic [3:0] FDone = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SORT,
		ST_EXEC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic clear_start;
		logic scan_step;
		logic sort_step;
		logic exec;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic scan_done;
		logic sort_done;
		logic run_over;
	} status_t;

endpackage

FILE: rtl/tdcs_datapath.sv
module tdcs_datapath import tdcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd_c,
	output status_t     stat,
	input  logic [2:0]  policy_q,
	input  logic [7:0]  time_slice_q,
	input  logic [3:0]  slot_count_q,
	input  logic [2:0]  slot_index,
	input  logic [15:0] arrival,
	input  logic [7:0]  burst_length,
	input  logic [7:0]  rank,
	input  logic [1:0]  io_requests,
	input  logic [7:0]  io_at_first,
	input  logic [7:0]  io_len_first,
	input  logic [7:0]  io_at_second,
	input  logic [7:0]  io_len_second,
	output logic [15:0] tick_number,
	output logic        cpu_busy,
	output logic [2:0]  cpu_slot,
	output logic        finished,
	output logic [2:0]  finished_slot,
	output logic [15:0] finished_wait,
	output logic [15:0] finished_turnaround,
	output logic        all_finished
);

	logic [15:0] arr_q [MaxProcs];
	logic [7:0]  bur_q [MaxProcs];
	logic [7:0]  rem_q [MaxProcs];
	logic [7:0]  rnk_q [MaxProcs];
	logic [1:0]  ioc_q [MaxProcs];
	logic [7:0]  iot_q [MaxProcs][2];
	logic [7:0]  iol_q [MaxProcs][2];
	logic [1:0]  ion_q [MaxProcs];
	logic [15:0] elig_q [MaxProcs];
	logic [15:0] wait_q [MaxProcs];
	logic [3:0]  flg_q [MaxProcs];
	logic [2:0]  rdy_q [MaxProcs];
	logic [CntW-1:0] rcnt_q;
	logic [2:0]  ioq_q [MaxProcs];
	logic [CntW-1:0] icnt_q;
	logic        run_v_q;
	logic [2:0]  run_s_q;
	logic        io_v_q;
	logic [2:0]  io_s_q;
	logic [7:0]  io_left_q;
	logic [7:0]  slice_q;
	logic [15:0] now_q;
	logic [CntW-1:0] done_q;
	logic [2:0]  ci_q;
	logic [2:0]  si_q, sj_q;
	logic [3:0]  n;
	logic [2:0]  pol;
	logic        by_rank, do_sort;
	logic [7:0]  ki, kj;

	// local working copies for the exec tick
	logic [3:0]  fl [MaxProcs];
	logic [15:0] wt [MaxProcs];
	logic [7:0]  rm [MaxProcs];
	logic [1:0]  nx [MaxProcs];
	logic [15:0] el [MaxProcs];
	logic [2:0]  rq [MaxProcs];
	logic [CntW-1:0] rc;
	logic [2:0]  iq [MaxProcs];
	logic [CntW-1:0] ic;
	logic        rv, iv;
	logic [2:0]  rs, is_s;
	logic [7:0]  il, sl;
	logic [15:0] nw;
	logic [CntW-1:0] dn;
	logic        busy_c, fin_c, take, trig;
	logic [2:0]  cpu_c, fs_c;
	logic [15:0] fw_c, ft_c, ftk;
	logic [8:0]  elapsed;
	logic [2:0]  hd;

	assign n = (slot_count_q > 4'(MaxProcs)) ? 4'(MaxProcs) : slot_count_q;
	assign pol = (policy_q > PolPprio) ? PolFcfs : policy_q;
	assign by_rank = (pol == PolPrio) || (pol == PolPprio);
	assign do_sort = (pol != PolFcfs) && (pol != PolRr);
	assign ki = by_rank ? rnk_q[rdy_q[si_q]] : rem_q[rdy_q[si_q]];
	assign kj = by_rank ? rnk_q[rdy_q[sj_q]] : rem_q[rdy_q[sj_q]];

	assign stat.clear_done = 1'b1;
	assign stat.scan_done = (4'(ci_q) + 4'd1 >= n) || (n == 4'd0);
	assign stat.sort_done = !do_sort || (rcnt_q < 4'd2) ||
		((4'(si_q) + 4'd2 >= rcnt_q) && (4'(sj_q) + 4'd1 >= rcnt_q));
	assign stat.run_over = (done_q >= n);

	always_comb begin
		for (int i = 0; i < MaxProcs; i++) begin
			fl[i] = flg_q[i];
			wt[i] = wait_q[i];
			rm[i] = rem_q[i];
			nx[i] = ion_q[i];
			el[i] = elig_q[i];
			rq[i] = rdy_q[i];
			iq[i] = ioq_q[i];
		end
		rc = rcnt_q;
		ic = icnt_q;
		rv = run_v_q;
		rs = run_s_q;
		iv = io_v_q;
		is_s = io_s_q;
		il = io_left_q;
		sl = slice_q;
		dn = done_q;
		fin_c = 1'b0;
		fs_c = '0;
		fw_c = '0;
		ft_c = '0;
		take = 1'b0;
		trig = 1'b0;
		elapsed = '0;
		ftk = '0;
		hd = '0;
		if (!rv) begin
			if (rc > 0) begin
				rs = rq[0];
				for (int i = 0; i < MaxProcs - 1; i++) rq[i] = rq[i + 1];
				rc = rc - 4'd1;
				fl[rs] = FRun;
				rv = 1'b1;
			end else begin
				rs = '0;
			end
		end
		if (pol != PolPprio) begin
			for (int i = 0; i < MaxProcs; i++)
				if (4'(i) < n && fl[i][0])
					wt[i] = (wt[i] == 16'hFFFF) ? wt[i] : wt[i] + 16'd1;
		end
		if (rv && rc > 0 && (pol == PolPsjf || pol == PolPprio)) begin
			hd = rq[0];
			take = (pol == PolPsjf) ? (rm[rs] > rm[hd]) : (rnk_q[rs] > rnk_q[hd]);
			if (take) begin
				fl[rs] = '0;
				rs = rq[0];
				for (int i = 0; i < MaxProcs - 1; i++) rq[i] = rq[i + 1];
				rc = rc - 4'd1;
				fl[rs] = FRun;
			end
		end
		if (pol == PolPprio) begin
			for (int i = 0; i < MaxProcs; i++)
				if (4'(i) < n && fl[i][0])
					wt[i] = (wt[i] == 16'hFFFF) ? wt[i] : wt[i] + 16'd1;
		end
		busy_c = rv;
		cpu_c = rv ? rs : 3'd0;
		if (rv) begin
			elapsed = {1'b0, bur_q[rs]} - {1'b0, rm[rs]};
			trig = ({1'b0, nx[rs]} < {1'b0, ioc_q[rs]}) &&
				(elapsed[7:0] + 8'd1 == iot_q[rs][nx[rs][0]]) && !elapsed[8] &&
				(elapsed[7:0] != 8'hFF);
			if (rm[rs] > 0) rm[rs] = rm[rs] - 8'd1;
			if (trig) begin
				fl[rs] = FWait;
				if (ic < 4'(MaxProcs)) begin
					iq[ic[2:0]] = rs;
					ic = ic + 4'd1;
				end
				if (pol == PolRr) sl = time_slice_q;
				if (rc > 0) begin
					rs = rq[0];
					for (int i = 0; i < MaxProcs - 1; i++) rq[i] = rq[i + 1];
					rc = rc - 4'd1;
					fl[rs] = FRun;
				end else begin
					rv = 1'b0;
					rs = '0;
				end
			end else begin
				if (pol == PolRr) sl = sl - 8'd1;
				if (rm[rs] == 0) begin
					ftk = (now_q == 16'hFFFF) ? now_q : now_q + 16'd1;
					if (pol == PolRr) sl = time_slice_q;
					fin_c = 1'b1;
					fs_c = rs;
					fw_c = wt[rs];
					ft_c = (ftk >= arr_q[rs]) ? ftk - arr_q[rs] : 16'd0;
					fl[rs] = FDone;
					dn = dn + 4'd1;
					if (rc > 0) begin
						rs = rq[0];
						for (int i = 0; i < MaxProcs - 1; i++) rq[i] = rq[i + 1];
						rc = rc - 4'd1;
						fl[rs] = FRun;
					end else begin
						rv = 1'b0;
						rs = '0;
					end
				end else if (pol == PolRr && sl == 0) begin
					fl[rs] = '0;
					sl = time_slice_q;
					if (rc > 0) begin
						rs = rq[0];
						for (int i = 0; i < MaxProcs - 1; i++) rq[i] = rq[i + 1];
						rc = rc - 4'd1;
						fl[rs] = FRun;
					end else begin
						rv = 1'b0;
						rs = '0;
					end
				end
			end
		end
		nw = (now_q == 16'hFFFF) ? now_q : now_q + 16'd1;
		if (!iv && ic > 0) begin
			is_s = iq[0];
			for (int i = 0; i < MaxProcs - 1; i++) iq[i] = iq[i + 1];
			ic = ic - 4'd1;
			iv = 1'b1;
			il = iol_q[is_s][nx[is_s][0]];
		end
		if (iv) begin
			if (il > 0) il = il - 8'd1;
			if (il == 0) begin
				nx[is_s] = nx[is_s] + 2'd1;
				fl[is_s] = '0;
				el[is_s] = (nw == 16'hFFFF) ? nw : nw + 16'd1;
				iv = 1'b0;
				is_s = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxProcs; i++) begin
				ion_q[i] <= '0;
				wait_q[i] <= '0;
				flg_q[i] <= '0;
			end
			rcnt_q <= '0;
			icnt_q <= '0;
			run_v_q <= 1'b0;
			run_s_q <= '0;
			io_v_q <= 1'b0;
			io_s_q <= '0;
			io_left_q <= '0;
			slice_q <= 8'd5;
			now_q <= '0;
			done_q <= '0;
			ci_q <= '0;
			si_q <= '0;
			sj_q <= 3'd1;
			tick_number <= '0;
			cpu_busy <= 1'b0;
			cpu_slot <= '0;
			finished <= 1'b0;
			finished_slot <= '0;
			finished_wait <= '0;
			finished_turnaround <= '0;
			all_finished <= 1'b0;
		end else begin
			if (cmd_c.load) begin
				arr_q[slot_index] <= arrival;
				bur_q[slot_index] <= burst_length;
				rnk_q[slot_index] <= rank;
				ioc_q[slot_index] <= (io_requests == 2'd3) ? 2'd2 : io_requests;
				if (io_requests[1] && io_at_first > io_at_second) begin
					iot_q[slot_index][0] <= io_at_second;
					iol_q[slot_index][0] <= io_len_second;
					iot_q[slot_index][1] <= io_at_first;
					iol_q[slot_index][1] <= io_len_first;
				end else begin
					iot_q[slot_index][0] <= io_at_first;
					iol_q[slot_index][0] <= io_len_first;
					iot_q[slot_index][1] <= io_at_second;
					iol_q[slot_index][1] <= io_len_second;
				end
			end
			if (cmd_c.clear_start) begin
				for (int i = 0; i < MaxProcs; i++) begin
					rem_q[i] <= (cmd_c.load && slot_index == 3'(i)) ? burst_length : bur_q[i];
					elig_q[i] <= (cmd_c.load && slot_index == 3'(i)) ? arrival : arr_q[i];
					ion_q[i] <= '0;
					wait_q[i] <= '0;
					flg_q[i] <= '0;
				end
				rcnt_q <= '0;
				icnt_q <= '0;
				run_v_q <= 1'b0;
				run_s_q <= '0;
				io_v_q <= 1'b0;
				io_s_q <= '0;
				io_left_q <= '0;
				slice_q <= time_slice_q;
				now_q <= '0;
				done_q <= '0;
			end
			if (cmd_c.scan_step) begin
				if (4'(ci_q) < n && elig_q[ci_q] <= now_q && flg_q[ci_q] == 4'd0 &&
						rcnt_q < 4'(MaxProcs)) begin
					rdy_q[rcnt_q[2:0]] <= ci_q;
					rcnt_q <= rcnt_q + 4'd1;
					flg_q[ci_q] <= FReady;
				end
				ci_q <= stat.scan_done ? 3'd0 : ci_q + 3'd1;
			end
			if (cmd_c.sort_step) begin
				if (do_sort && 4'(sj_q) < rcnt_q && ki > kj) begin
					rdy_q[si_q] <= rdy_q[sj_q];
					rdy_q[sj_q] <= rdy_q[si_q];
				end
				if (stat.sort_done) begin
					si_q <= '0;
					sj_q <= 3'd1;
				end else if (4'(sj_q) + 4'd1 >= rcnt_q) begin
					si_q <= si_q + 3'd1;
					sj_q <= si_q + 3'd2;
				end else begin
					sj_q <= sj_q + 3'd1;
				end
			end
			if (cmd_c.exec) begin
				for (int i = 0; i < MaxProcs; i++) begin
					flg_q[i] <= fl[i];
					wait_q[i] <= wt[i];
					rem_q[i] <= rm[i];
					ion_q[i] <= nx[i];
					elig_q[i] <= el[i];
					rdy_q[i] <= rq[i];
					ioq_q[i] <= iq[i];
				end
				rcnt_q <= rc;
				icnt_q <= ic;
				run_v_q <= rv;
				run_s_q <= rs;
				io_v_q <= iv;
				io_s_q <= is_s;
				io_left_q <= il;
				slice_q <= sl;
				now_q <= nw;
				done_q <= dn;
				tick_number <= now_q;
				cpu_busy <= busy_c;
				cpu_slot <= cpu_c;
				finished_slot <= fs_c;
				finished_wait <= fw_c;
				finished_turnaround <= ft_c;
				all_finished <= (dn >= n);
			end
			if (cmd_c.emit) begin
				tick_number <= now_q;
				cpu_busy <= 1'b0;
				cpu_slot <= '0;
				finished_slot <= '0;
				finished_wait <= '0;
				finished_turnaround <= '0;
				all_finished <= 1'b1;
			end
			finished <= cmd_c.exec ? fin_c : 1'b0;
		end
	end

endmodule

FILE: rtl/tdcs_ctrl.sv
module tdcs_ctrl import tdcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    cmd,
	input  status_t stat,
	output cmd_t    cmd_c,
	output logic    busy,
	output logic    strobe
);

	state_t state_q, state_d;
	logic   strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe_q <= cmd_c.exec || cmd_c.emit;
		end
	end

	assign strobe = strobe_q;

	always_comb begin
		state_d = state_q;
		cmd_c = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = strobe_q;
				if (start && !strobe_q) begin
					if (!cmd) begin
						cmd_c.load = 1'b1;
						cmd_c.clear_start = 1'b1;
					end else if (stat.run_over) begin
						cmd_c.emit = 1'b1;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd_c.scan_step = 1'b1;
				if (stat.scan_done) state_d = ST_SORT;
			end
			ST_SORT: begin
				cmd_c.sort_step = 1'b1;
				if (stat.sort_done) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd_c.exec = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/tick_driven_cpu_scheduler_unit.sv
// a load gives no word; a tick on a finished run strobes next cycle
// a tick scans n = min(slot count, 8) slots, then sorts the ready words (sjf, priority and their
// preemptive forms, with two or more ready), then executes; strobe is registered from the exec
// one item at a time: a tick is taken only while busy is low, a load every cycle while busy is low
// reset clears control, run state and configuration (policy fcfs, slice 5, count 3)
// the receiver cannot stall: each word is shown for one cycle with strobe
module tick_driven_cpu_scheduler_unit import tdcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [2:0]  slot_index,
	input  logic [15:0] arrival,
	input  logic [7:0]  burst_length,
	input  logic [7:0]  rank,
	input  logic [1:0]  io_requests,
	input  logic [7:0]  io_at_first,
	input  logic [7:0]  io_len_first,
	input  logic [7:0]  io_at_second,
	input  logic [7:0]  io_len_second,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        strobe,
	output logic [15:0] tick_number,
	output logic        cpu_busy,
	output logic [2:0]  cpu_slot,
	output logic        finished,
	output logic [2:0]  finished_slot,
	output logic [15:0] finished_wait,
	output logic [15:0] finished_turnaround,
	output logic        all_finished
);

	cmd_t       cmd_c;
	status_t    stat;
	logic [2:0] policy_q;
	logic [7:0] time_slice_q;
	logic [3:0] slot_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= PolFcfs;
			time_slice_q <= 8'd5;
			slot_count_q <= 4'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgPolicy: policy_q <= cfg_data[2:0];
				CfgSlice: time_slice_q <= cfg_data;
				CfgCount: slot_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	tdcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .stat(stat),
		.cmd_c(cmd_c), .busy(busy), .strobe(strobe)
	);

	tdcs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_c(cmd_c), .stat(stat),
		.policy_q(policy_q), .time_slice_q(time_slice_q),
		.slot_count_q(slot_count_q), .slot_index(slot_index),
		.arrival(arrival), .burst_length(burst_length), .rank(rank),
		.io_requests(io_requests), .io_at_first(io_at_first),
		.io_len_first(io_len_first), .io_at_second(io_at_second),
		.io_len_second(io_len_second), .tick_number(tick_number),
		.cpu_busy(cpu_busy), .cpu_slot(cpu_slot), .finished(finished),
		.finished_slot(finished_slot), .finished_wait(finished_wait),
		.finished_turnaround(finished_turnaround), .all_finished(all_finished)
	);

endmodule
